// ===== hw/rtl/sui_pkg.sv =====
package sui_pkg;

  localparam int SET_SIZE_DEF   = 20;
  localparam int VALUE_BITS_DEF = 8;

  localparam int OP_W     = 2;
  localparam int VALUE_W  = 8;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int COMMON_W = 5;
  localparam int UNION_W  = 6;

  localparam logic [OP_W-1:0] OP_INS_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_INS_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_REPORT = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INTER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UNION = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SUM   = 2'd3;

  localparam logic [STATUS_W-1:0] STS_ACCEPT = 2'd0;
  localparam logic [STATUS_W-1:0] STS_DUP    = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL   = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_INS_A,
    CMD_INS_B,
    CMD_CLEAR,
    CMD_START,
    CMD_REWIND,
    CMD_INTER,
    CMD_UNION_A,
    CMD_UNION_B,
    CMD_SUM
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic end_a;
    logic end_b;
  } dp_status_t;

endpackage

// ===== hw/rtl/sui_datapath.sv =====
module sui_datapath #(
  parameter int SET_SIZE   = sui_pkg::SET_SIZE_DEF,
  parameter int VALUE_BITS = sui_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sui_pkg::cmd_t                 cmd,
  output sui_pkg::dp_status_t           dp_status,
  input  logic [sui_pkg::VALUE_W-1:0]   item_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sui_pkg::KIND_W-1:0]    kind,
  output logic [sui_pkg::VALUE_W-1:0]   element,
  output logic [sui_pkg::STATUS_W-1:0]  status,
  output logic [sui_pkg::COMMON_W-1:0]  common_count,
  output logic [sui_pkg::UNION_W-1:0]   union_count,
  output logic                          last
);

  localparam int SB = (VALUE_BITS < sui_pkg::VALUE_W) ? VALUE_BITS : sui_pkg::VALUE_W;
  localparam int FW = $clog2(SET_SIZE + 1);
  localparam int IW = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;

  logic [SB-1:0] store_a [SET_SIZE];
  logic [SB-1:0] store_b [SET_SIZE];
  logic [FW-1:0] fill_a;
  logic [FW-1:0] fill_b;
  logic [FW-1:0] idx;
  logic [sui_pkg::COMMON_W-1:0] common;
  logic [sui_pkg::UNION_W-1:0]  uni;

  logic [SB-1:0] v;
  logic [SB-1:0] a_cur;
  logic [SB-1:0] b_cur;
  logic dup_a, dup_b, a_in_b, b_in_a;
  logic full_a, full_b;
  logic out_free;

  logic                          ld;
  logic [sui_pkg::KIND_W-1:0]    ld_kind;
  logic [sui_pkg::VALUE_W-1:0]   ld_elem;
  logic [sui_pkg::STATUS_W-1:0]  ld_status;
  logic [sui_pkg::COMMON_W-1:0]  ld_common;
  logic [sui_pkg::UNION_W-1:0]   ld_union;
  logic                          ld_last;

  assign v        = item_value[SB-1:0];
  assign a_cur    = store_a[idx[IW-1:0]];
  assign b_cur    = store_b[idx[IW-1:0]];
  assign full_a   = (fill_a == FW'(SET_SIZE));
  assign full_b   = (fill_b == FW'(SET_SIZE));
  assign out_free = !out_valid || out_ready;

  assign dp_status.out_free = out_free;
  assign dp_status.end_a    = (idx >= fill_a);
  assign dp_status.end_b    = (idx >= fill_b);

  // Parallel membership checks; only entries below the fill count take part.
  always_comb begin
    dup_a  = 1'b0;
    dup_b  = 1'b0;
    a_in_b = 1'b0;
    b_in_a = 1'b0;
    for (int i = 0; i < SET_SIZE; i++) begin
      if (FW'(i) < fill_a) begin
        dup_a  = dup_a  | (store_a[i] == v);
        b_in_a = b_in_a | (store_a[i] == b_cur);
      end
      if (FW'(i) < fill_b) begin
        dup_b  = dup_b  | (store_b[i] == v);
        a_in_b = a_in_b | (store_b[i] == a_cur);
      end
    end
  end

  always_comb begin
    ld        = 1'b0;
    ld_kind   = sui_pkg::KIND_ACK;
    ld_elem   = '0;
    ld_status = sui_pkg::STS_ACCEPT;
    ld_common = '0;
    ld_union  = '0;
    ld_last   = 1'b0;
    case (cmd)
      sui_pkg::CMD_INS_A: begin
        ld        = 1'b1;
        ld_last   = 1'b1;
        ld_status = dup_a ? sui_pkg::STS_DUP :
                    full_a ? sui_pkg::STS_FULL : sui_pkg::STS_ACCEPT;
      end
      sui_pkg::CMD_INS_B: begin
        ld        = 1'b1;
        ld_last   = 1'b1;
        ld_status = dup_b ? sui_pkg::STS_DUP :
                    full_b ? sui_pkg::STS_FULL : sui_pkg::STS_ACCEPT;
      end
      sui_pkg::CMD_CLEAR: begin
        ld      = 1'b1;
        ld_last = 1'b1;
      end
      sui_pkg::CMD_INTER: begin
        ld      = a_in_b;
        ld_kind = sui_pkg::KIND_INTER;
        ld_elem = sui_pkg::VALUE_W'(a_cur);
      end
      sui_pkg::CMD_UNION_A: begin
        ld      = 1'b1;
        ld_kind = sui_pkg::KIND_UNION;
        ld_elem = sui_pkg::VALUE_W'(a_cur);
      end
      sui_pkg::CMD_UNION_B: begin
        ld      = !b_in_a;
        ld_kind = sui_pkg::KIND_UNION;
        ld_elem = sui_pkg::VALUE_W'(b_cur);
      end
      sui_pkg::CMD_SUM: begin
        ld        = 1'b1;
        ld_kind   = sui_pkg::KIND_SUM;
        ld_common = common;
        ld_union  = uni;
        ld_last   = 1'b1;
      end
      default: begin
        ld = 1'b0;
      end
    endcase
  end

  // Set stores: append at the fill position, no reset.
  always_ff @(posedge clk) begin
    if (cmd == sui_pkg::CMD_INS_A && !dup_a && !full_a) begin
      store_a[fill_a[IW-1:0]] <= v;
    end
    if (cmd == sui_pkg::CMD_INS_B && !dup_b && !full_b) begin
      store_b[fill_b[IW-1:0]] <= v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_a    <= '0;
      fill_b    <= '0;
      idx       <= '0;
      common    <= '0;
      uni       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd)
        sui_pkg::CMD_INS_A: begin
          if (!dup_a && !full_a) fill_a <= fill_a + 1'b1;
        end
        sui_pkg::CMD_INS_B: begin
          if (!dup_b && !full_b) fill_b <= fill_b + 1'b1;
        end
        sui_pkg::CMD_CLEAR: begin
          fill_a <= '0;
          fill_b <= '0;
        end
        sui_pkg::CMD_START: begin
          idx    <= '0;
          common <= '0;
          uni    <= '0;
        end
        sui_pkg::CMD_REWIND: begin
          idx <= '0;
        end
        sui_pkg::CMD_INTER: begin
          idx <= idx + 1'b1;
          if (a_in_b) common <= common + 1'b1;
        end
        sui_pkg::CMD_UNION_A: begin
          idx <= idx + 1'b1;
          uni <= uni + 1'b1;
        end
        sui_pkg::CMD_UNION_B: begin
          idx <= idx + 1'b1;
          if (!b_in_a) uni <= uni + 1'b1;
        end
        default: begin
          idx <= idx;
        end
      endcase
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (ld) begin
      kind         <= ld_kind;
      element      <= ld_elem;
      status       <= ld_status;
      common_count <= ld_common;
      union_count  <= ld_union;
      last         <= ld_last;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (fill_a <= FW'(SET_SIZE)) && (fill_b <= FW'(SET_SIZE)))
    else $error("set fill count beyond capacity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ld |-> out_free)
    else $error("result loaded over a pending item");

  a_ins_b_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd == sui_pkg::CMD_INS_B && !dup_b && !full_b) |=>
      (fill_b == FW'($past(fill_b) + 1'b1)))
    else $error("accepted insert into B did not grow the set");

endmodule

// ===== hw/rtl/sui_ctrl.sv =====
module sui_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [sui_pkg::OP_W-1:0]   opcode,
  input  sui_pkg::dp_status_t        dp_status,
  output sui_pkg::cmd_t              cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_INTER = 5'b00010,
    S_UA    = 5'b00100,
    S_UB    = 5'b01000,
    S_SUM   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = sui_pkg::CMD_NONE;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = dp_status.out_free;
        if (in_valid && dp_status.out_free) begin
          case (opcode)
            sui_pkg::OP_INS_A: cmd = sui_pkg::CMD_INS_A;
            sui_pkg::OP_INS_B: cmd = sui_pkg::CMD_INS_B;
            sui_pkg::OP_CLEAR: cmd = sui_pkg::CMD_CLEAR;
            sui_pkg::OP_REPORT: begin
              cmd        = sui_pkg::CMD_START;
              state_next = S_INTER;
            end
            default: cmd = sui_pkg::CMD_NONE;
          endcase
        end
      end
      S_INTER: begin
        if (dp_status.out_free) begin
          if (dp_status.end_a) begin
            cmd        = sui_pkg::CMD_REWIND;
            state_next = S_UA;
          end else begin
            cmd = sui_pkg::CMD_INTER;
          end
        end
      end
      S_UA: begin
        if (dp_status.out_free) begin
          if (dp_status.end_a) begin
            cmd        = sui_pkg::CMD_REWIND;
            state_next = S_UB;
          end else begin
            cmd = sui_pkg::CMD_UNION_A;
          end
        end
      end
      S_UB: begin
        if (dp_status.end_b) begin
          state_next = S_SUM;
        end else if (dp_status.out_free) begin
          cmd = sui_pkg::CMD_UNION_B;
        end
      end
      S_SUM: begin
        if (dp_status.out_free) begin
          cmd        = sui_pkg::CMD_SUM;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_report_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && in_ready && opcode == sui_pkg::OP_REPORT) |=>
      (state == S_INTER))
    else $error("report item did not start the intersection pass");

  a_inter_to_union: assert property (@(posedge clk) disable iff (rst)
    (state == S_INTER && dp_status.out_free && dp_status.end_a) |=> (state == S_UA))
    else $error("intersection pass did not hand over to union pass");

  a_sum_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM && dp_status.out_free) |=> (state == S_IDLE))
    else $error("summary emitted without returning to idle");

endmodule

// ===== hw/rtl/set_union_intersection_core.sv =====
// Two small sets A and B of distinct values, held in registers. An insert or
// clear item is answered by a single acknowledge; a new item is taken every
// cycle as long as results are taken. A report item walks the stored entries
// through a single read position shared by both sets, one entry per cycle
// while results are taken, comparing it against the other set in parallel,
// and emits the intersection (A order), the union (A, then B minus A) and a
// closing summary with both counts. No new item is taken during a report.
module set_union_intersection_core #(
  parameter int SET_SIZE   = sui_pkg::SET_SIZE_DEF,
  parameter int VALUE_BITS = sui_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sui_pkg::OP_W-1:0]      opcode,
  input  logic [sui_pkg::VALUE_W-1:0]   item_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sui_pkg::KIND_W-1:0]    kind,
  output logic [sui_pkg::VALUE_W-1:0]   element,
  output logic [sui_pkg::STATUS_W-1:0]  status,
  output logic [sui_pkg::COMMON_W-1:0]  common_count,
  output logic [sui_pkg::UNION_W-1:0]   union_count,
  output logic                          last
);

  sui_pkg::cmd_t       cmd;
  sui_pkg::dp_status_t dp_status;

  sui_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  sui_datapath #(
    .SET_SIZE   (SET_SIZE),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .dp_status    (dp_status),
    .item_value   (item_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .element      (element),
    .status       (status),
    .common_count (common_count),
    .union_count  (union_count),
    .last         (last)
  );

endmodule

// ===== dv/tb_set_union_intersection_core.sv =====
module tb_set_union_intersection_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sui_pkg::*;

  localparam int SET_SIZE     = SET_SIZE_DEF;
  localparam int VALUE_BITS   = VALUE_BITS_DEF;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 3 * SET_SIZE + 20;

  typedef logic [VALUE_W-1:0] value_t;
  localparam value_t VALUE_MASK = value_t'((64'd1 << VALUE_BITS) - 1);

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [VALUE_W-1:0]  element;
    logic [STATUS_W-1:0] status;
    logic [COMMON_W-1:0] common_count;
    logic [UNION_W-1:0]  union_count;
    logic                last;
  } result_t;

  class set_pair_tracker;
    value_t  members[2][SET_SIZE];
    int      fill[2];
    result_t due[$];
    int      mismatches;

    function bit holds(int s, value_t v);
      for (int k = 0; k < fill[s]; k++) begin
        if (members[s][k] == v) return 1'b1;
      end
      return 1'b0;
    endfunction

    // Duplicate check wins over the full check.
    function logic [STATUS_W-1:0] insert_member(int s, value_t v);
      if (holds(s, v)) return STS_DUP;
      if (fill[s] >= SET_SIZE) return STS_FULL;
      members[s][fill[s]] = v;
      fill[s]++;
      return STS_ACCEPT;
    endfunction

    function void await_result(logic [KIND_W-1:0] k, value_t e, logic [STATUS_W-1:0] st,
                               int common, int uni, logic fin);
      result_t r;
      r.kind         = k;
      r.element      = e;
      r.status       = st;
      r.common_count = common[COMMON_W-1:0];
      r.union_count  = uni[UNION_W-1:0];
      r.last         = fin;
      due.push_back(r);
    endfunction

    function void apply_item(logic [OP_W-1:0] op, value_t raw);
      value_t v;
      int     common;
      int     uni;
      v      = raw & VALUE_MASK;
      common = 0;
      uni    = 0;
      case (op)
        OP_INS_A: await_result(KIND_ACK, '0, insert_member(0, v), 0, 0, 1'b1);
        OP_INS_B: await_result(KIND_ACK, '0, insert_member(1, v), 0, 0, 1'b1);
        OP_CLEAR: begin
          fill[0] = 0;
          fill[1] = 0;
          await_result(KIND_ACK, '0, STS_ACCEPT, 0, 0, 1'b1);
        end
        OP_REPORT: begin
          for (int k = 0; k < fill[0]; k++) begin
            if (holds(1, members[0][k])) begin
              await_result(KIND_INTER, members[0][k], STS_ACCEPT, 0, 0, 1'b0);
              common++;
            end
          end
          for (int k = 0; k < fill[0]; k++) begin
            await_result(KIND_UNION, members[0][k], STS_ACCEPT, 0, 0, 1'b0);
            uni++;
          end
          // B members not already in A, in B's order
          for (int k = 0; k < fill[1]; k++) begin
            if (!holds(0, members[1][k])) begin
              await_result(KIND_UNION, members[1][k], STS_ACCEPT, 0, 0, 1'b0);
              uni++;
            end
          end
          await_result(KIND_SUM, '0, STS_ACCEPT, common, uni, 1'b1);
        end
      endcase
    endfunction

    function void compare_result(result_t got);
      result_t want;
      if (due.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with nothing pending: kind=%0d elem=%0d sts=%0d cc=%0d uc=%0d last=%0d",
                   $realtime, got.kind, got.element, got.status, got.common_count,
                   got.union_count, got.last);
        mismatches++;
        return;
      end
      want = due.pop_front();
      if (got.kind !== want.kind || got.element !== want.element ||
          got.status !== want.status || got.common_count !== want.common_count ||
          got.union_count !== want.union_count || got.last !== want.last) begin
        if (mismatches < 10) begin
          $display("%0t: mismatch exp kind=%0d elem=%0d sts=%0d cc=%0d uc=%0d last=%0d",
                   $realtime, want.kind, want.element, want.status, want.common_count,
                   want.union_count, want.last);
          $display("%0t:          got kind=%0d elem=%0d sts=%0d cc=%0d uc=%0d last=%0d",
                   $realtime, got.kind, got.element, got.status, got.common_count,
                   got.union_count, got.last);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     opcode       = OP_INS_A;
  value_t              item_value   = '0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [KIND_W-1:0]   kind;
  logic [VALUE_W-1:0]  element;
  logic [STATUS_W-1:0] status;
  logic [COMMON_W-1:0] common_count;
  logic [UNION_W-1:0]  union_count;
  logic                last;

  set_pair_tracker tracker = new();
  int send_idle_pct = 34;
  int recv_idle_pct = 50;
  int quiet_cycles  = 0;

  set_union_intersection_core #(
    .SET_SIZE   (SET_SIZE),
    .VALUE_BITS (VALUE_BITS)
  ) dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && in_ready) tracker.apply_item(opcode, item_value);
      if (out_valid && out_ready)
        tracker.compare_result(result_t'({kind, element, status, common_count,
                                          union_count, last}));
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("set_union_intersection_core regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input value_t v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    item_value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off the sender until every pending result is back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.due.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int quota);
    int               sent;
    int               n_ins;
    int               span;
    int               lean;
    value_t           base;
    logic [OP_W-1:0]  op;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(OP_W'($urandom_range(0, 3)), value_t'($urandom));
        sent++;
      end else begin
        if ($urandom_range(0, 9) < 7) begin
          send_item(OP_CLEAR, value_t'($urandom));
          sent++;
        end
        // Mostly short fills over a narrow window; now and then push one set past full.
        if ($urandom_range(0, 7) == 0) begin
          n_ins = $urandom_range(24, 45);
          span  = 255;
          lean  = $urandom_range(0, 1);
        end else begin
          n_ins = $urandom_range(0, 10);
          span  = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(3, 24);
          lean  = 2;
        end
        base = value_t'($urandom);
        for (int k = 0; k < n_ins; k++) begin
          if (lean == 2)
            op = $urandom_range(0, 1) ? OP_INS_B : OP_INS_A;
          else if ($urandom_range(0, 4) == 0)
            op = lean ? OP_INS_A : OP_INS_B;
          else
            op = lean ? OP_INS_B : OP_INS_A;
          send_item(op, base + value_t'($urandom_range(0, span)));
          sent++;
        end
        send_item(OP_REPORT, value_t'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_item(OP_REPORT, 8'h00);
    send_item(OP_INS_A, 8'h00);
    send_item(OP_INS_A, 8'hFF);
    for (int k = 1; k <= SET_SIZE - 2; k++) send_item(OP_INS_A, value_t'(k * 13));
    send_item(OP_INS_A, 8'hFF);
    send_item(OP_INS_A, 8'hAA);
    send_item(OP_INS_B, 8'hFF);
    send_item(OP_INS_B, 8'h80);
    send_item(OP_INS_B, 8'h80);
    send_item(OP_REPORT, 8'hFF);
    send_item(OP_CLEAR, 8'h55);
    send_item(OP_REPORT, 8'hAA);
    drain_results();

    random_phase(94);
    drain_results();
    send_idle_pct = 50;
    recv_idle_pct = 34;
    random_phase(94);
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(94);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.due.size() == 0)
      $display("set_union_intersection_core regression: pass");
    else
      $display("set_union_intersection_core regression: fail");
    $finish;
  end

endmodule
